// ===== sv/xoca_pkg.sv =====
// Package for the XYZ offset colour adjust block: widths, matrices, tables and register indexes.
package xoca_pkg;

    localparam int LIN_W = 17;
    localparam int PIX_W = 8;
    localparam int OFF_W = 8;
    localparam int IDX_W = 2;
    localparam int OFFQ_W = 18;
    localparam int FPROD_W = 33;
    localparam int IPROD_W = 37;
    localparam int BIG_W = 192;
    localparam int Q16_ONE = 65536;
    localparam int OFF_DIV = 100;

    typedef logic [LIN_W-1:0] lin_t;
    typedef logic [PIX_W-1:0] pix_t;
    typedef logic [OFF_W-1:0] off_raw_t;
    typedef logic [IDX_W-1:0] cfg_idx_t;
    typedef logic signed [OFFQ_W-1:0] off_t;
    typedef logic [15:0] fwd_coef_t;
    typedef logic signed [18:0] inv_coef_t;
    typedef lin_t dec_tab_t [256];
    typedef pix_t enc_tab_t [256];
    typedef off_t off_tab_t [256];
    typedef fwd_coef_t fwd_mat_t [3][3];
    typedef inv_coef_t inv_mat_t [3][3];
    typedef logic [BIG_W-1:0] big_t;

    localparam cfg_idx_t REG_OFFSET_X = 2'd0;
    localparam cfg_idx_t REG_OFFSET_Y = 2'd1;
    localparam cfg_idx_t REG_OFFSET_Z = 2'd2;

    localparam lin_t ONE_Q16 = lin_t'(Q16_ONE);

    localparam fwd_mat_t FWD_M = '{
        '{16'd37793, 16'd12161, 16'd12336},
        '{16'd19486, 16'd41115, 16'd4934},
        '{16'd1771,  16'd4633,  16'd64968}
    };

    localparam inv_mat_t INV_M = '{
        '{19'sd133798, -19'sd37028, -19'sd22592},
        '{-19'sd63520, 19'sd122944, 19'sd2724},
        '{19'sd881,    -19'sd7757,  19'sd66530}
    };

    function automatic big_t big_pow(input int unsigned base, input int unsigned ex);
        big_t r;
        r = big_t'(1);
        for (int unsigned k = 0; k < ex; k++) begin
            r = r * big_t'(base);
        end
        return r;
    endfunction

    // v - 1/2 <= 65536 * (i/255)^(11/5), exact in integers
    function automatic bit dec_ok(input int unsigned i, input int unsigned v);
        big_t l;
        big_t r;
        if (v == 0) begin
            return 1'b1;
        end
        l = big_pow(2 * v - 1, 5) * big_pow(255, 11);
        r = big_pow(i, 11) * big_pow(131072, 5);
        return l <= r;
    endfunction

    // k - 1/2 <= 255 * (i/255)^(5/11), exact in integers
    function automatic bit enc_ok(input int unsigned i, input int unsigned k);
        big_t l;
        big_t r;
        if (k == 0) begin
            return 1'b1;
        end
        l = big_pow(2 * k - 1, 11) * big_pow(255, 5);
        r = big_pow(i, 5) * big_pow(510, 11);
        return l <= r;
    endfunction

    function automatic dec_tab_t build_dec_tab();
        dec_tab_t t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        for (int unsigned i = 0; i < 256; i++) begin
            lo = 0;
            hi = Q16_ONE;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (dec_ok(i, mid)) begin
                    lo = mid;
                end
                else begin
                    hi = mid - 1;
                end
            end
            t[i] = lin_t'(lo);
        end
        return t;
    endfunction

    function automatic enc_tab_t build_enc_tab();
        enc_tab_t t;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        for (int unsigned i = 0; i < 256; i++) begin
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                if (enc_ok(i, mid)) begin
                    lo = mid;
                end
                else begin
                    hi = mid - 1;
                end
            end
            t[i] = pix_t'(lo);
        end
        return t;
    endfunction

    // offset register bit pattern -> Q16 term, rounded half away from zero
    function automatic off_tab_t build_off_tab();
        off_tab_t t;
        int s;
        int m;
        int q;
        for (int i = 0; i < 256; i++) begin
            s = (i >= 128) ? i - 256 : i;
            m = (s < 0) ? -s : s;
            q = (m * Q16_ONE + OFF_DIV / 2) / OFF_DIV;
            t[i] = off_t'((s < 0) ? -q : q);
        end
        return t;
    endfunction

    localparam dec_tab_t DEC_TAB = build_dec_tab();
    localparam enc_tab_t ENC_TAB = build_enc_tab();
    localparam off_tab_t OFF_TAB = build_off_tab();

endpackage

// ===== sv/xyz_offset_color_adjust.sv =====
// Top level: Adobe RGB pixel through XYZ with per-axis offset, six-stage pipeline.
//
//  channel  | ports                                  | request taken when
//  ---------+----------------------------------------+-----------------------------
//  pixel in | start, busy, red_in, green_in, blue_in | start high, busy low
//  pixel out| done, red_out, green_out, blue_out     | done high (one cycle)
//  config   | cfg_valid, cfg_ready, cfg_index,       | cfg_valid and cfg_ready high
//           | cfg_data                               |
//
// One pixel per cycle; each result leaves through the six register stages: decode table,
// forward multiply, sum/offset/clamp, inverse multiply, sum/clamp, encode table.
// Reset clears the stage valid bits and the offsets; busy stays low, nothing stalls.
module xyz_offset_color_adjust
    import xoca_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  pix_t     red_in,
    input  pix_t     green_in,
    input  pix_t     blue_in,
    output logic     done,
    output pix_t     red_out,
    output pix_t     green_out,
    output pix_t     blue_out,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  cfg_idx_t cfg_index,
    input  off_raw_t cfg_data
);

    off_raw_t offset_x_reg, offset_y_reg, offset_z_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic accept;

    lin_t                         lin_reg [3];
    lin_t                         lin_next [3];
    logic [FPROD_W-1:0]           fprod_reg [3][3];
    logic [FPROD_W-1:0]           fprod_next [3][3];
    off_t                         off2_reg [3];
    off_t                         off2_next [3];
    lin_t                         xyz_reg [3];
    lin_t                         xyz_next [3];
    logic signed [IPROD_W-1:0]    iprod_reg [3][3];
    logic signed [IPROD_W-1:0]    iprod_next [3][3];
    lin_t                         rgb_reg [3];
    lin_t                         rgb_next [3];
    pix_t                         pix_reg [3];
    pix_t                         pix_next [3];

    logic [34:0]                  fsum [3];
    logic [18:0]                  fround [3];
    logic signed [19:0]           fadj [3];
    logic signed [39:0]           isum [3];
    logic [23:0]                  ish [3];
    logic [24:0]                  eprod [3];

    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            offset_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OFFSET_X: offset_x_reg <= cfg_data;
                REG_OFFSET_Y: offset_y_reg <= cfg_data;
                REG_OFFSET_Z: offset_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // stage 1: linearise
    always_comb
    begin
        lin_next[0] = DEC_TAB[red_in];
        lin_next[1] = DEC_TAB[green_in];
        lin_next[2] = DEC_TAB[blue_in];
    end

    // stage 2: forward products, offset terms
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                fprod_next[a][c] = FPROD_W'(FWD_M[a][c]) * FPROD_W'(lin_reg[c]);
            end
        end
        off2_next[0] = OFF_TAB[offset_x_reg];
        off2_next[1] = OFF_TAB[offset_y_reg];
        off2_next[2] = OFF_TAB[offset_z_reg];
    end

    // stage 3: round, add offset, clamp to unit
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            fsum[a]   = 35'(fprod_reg[a][0]) + 35'(fprod_reg[a][1]) + 35'(fprod_reg[a][2])
                        + 35'(32768);
            fround[a] = fsum[a][34:16];
            fadj[a]   = $signed({1'b0, fround[a]}) + 20'(off2_reg[a]);
            if (fadj[a] < 0)
            begin
                xyz_next[a] = '0;
            end
            else if (fadj[a] > 20'sd65536)
            begin
                xyz_next[a] = ONE_Q16;
            end
            else
            begin
                xyz_next[a] = fadj[a][LIN_W-1:0];
            end
        end
    end

    // stage 4: inverse products
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                iprod_next[c][a] = IPROD_W'(INV_M[c][a])
                                   * IPROD_W'($signed({1'b0, xyz_reg[a]}));
            end
        end
    end

    // stage 5: round, clamp to unit
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            isum[c] = 40'(iprod_reg[c][0]) + 40'(iprod_reg[c][1]) + 40'(iprod_reg[c][2])
                      + 40'sd32768;
            ish[c]  = isum[c][39:16];
            if (isum[c] < 0)
            begin
                rgb_next[c] = '0;
            end
            else if (ish[c] > 24'd65536)
            begin
                rgb_next[c] = ONE_Q16;
            end
            else
            begin
                rgb_next[c] = ish[c][LIN_W-1:0];
            end
        end
    end

    // stage 6: index = floor(v * 255), encode
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            eprod[c]    = {rgb_reg[c], 8'b0} - 25'(rgb_reg[c]);
            pix_next[c] = ENC_TAB[eprod[c][23:16]];
        end
    end

    always_ff @(posedge clk)
    begin
        lin_reg    <= lin_next;
        fprod_reg  <= fprod_next;
        off2_reg   <= off2_next;
        xyz_reg    <= xyz_next;
        iprod_reg  <= iprod_next;
        rgb_reg    <= rgb_next;
        pix_reg    <= pix_next;
    end

    assign done      = v6_reg;
    assign red_out   = pix_reg[0];
    assign green_out = pix_reg[1];
    assign blue_out  = pix_reg[2];

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("request did not produce a result six cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without a matching request");

    a_xyz_unit: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (xyz_reg[0] <= ONE_Q16 && xyz_reg[1] <= ONE_Q16 && xyz_reg[2] <= ONE_Q16))
        else $error("XYZ stage out of unit range");

    a_rgb_unit: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (rgb_reg[0] <= ONE_Q16 && rgb_reg[1] <= ONE_Q16 && rgb_reg[2] <= ONE_Q16))
        else $error("linear RGB stage out of unit range");

endmodule
